@@ hw/rtl/bsl_pkg.sv @@
`timescale 1ns / 1ps

package bsl_pkg;

    localparam int TEXT_CAPACITY = 100;
    localparam logic [6:0] MAX_STORED = 7'(TEXT_CAPACITY - 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        KW_NONE = 3'd0,
        KW_I    = 3'd1,
        KW_IN   = 3'd2,
        KW_INT  = 3'd3,
        KW_IF   = 3'd4,
        KW_DEAD = 3'd5
    } kw_t;

    typedef enum logic [3:0] {
        KIND_INT     = 4'd0,
        KIND_IDENT   = 4'd1,
        KIND_NUMBER  = 4'd2,
        KIND_ASSIGN  = 4'd3,
        KIND_PLUS    = 4'd4,
        KIND_MINUS   = 4'd5,
        KIND_STAR    = 4'd6,
        KIND_SLASH   = 4'd7,
        KIND_GREATER = 4'd8,
        KIND_IF      = 4'd9,
        KIND_LBRACE  = 4'd10,
        KIND_RBRACE  = 4'd11,
        KIND_SEMI    = 4'd12,
        KIND_UNKNOWN = 4'd13,
        KIND_END     = 4'd14
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [6:0] length;
        logic [7:0] first;
        logic       last;
    } token_t;

    typedef struct packed {
        logic   push0;
        logic   push1;
        token_t res0;
        token_t res1;
    } scan_out_t;

    typedef struct packed {
        logic [CNT_W-1:0] level;
        logic             room2;
    } queue_status_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'd48) && (c <= 8'd57);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
    endfunction

    function automatic kind_t punct_kind(input logic [7:0] c);
        kind_t k;
        unique case (c)
            8'h3D:   k = KIND_ASSIGN;
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h2A:   k = KIND_STAR;
            8'h2F:   k = KIND_SLASH;
            8'h3E:   k = KIND_GREATER;
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            8'h3B:   k = KIND_SEMI;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic kw_t kw_next(input kw_t p, input logic [7:0] c);
        kw_t n;
        n = KW_DEAD;
        if (p == KW_NONE && c == 8'h69)
        begin
            n = KW_I;
        end
        else if (p == KW_I && c == 8'h6E)
        begin
            n = KW_IN;
        end
        else if (p == KW_I && c == 8'h66)
        begin
            n = KW_IF;
        end
        else if (p == KW_IN && c == 8'h74)
        begin
            n = KW_INT;
        end
        return n;
    endfunction

endpackage

@@ hw/rtl/byte_stream_lexer.sv @@
// A token is written into the token queue in the same cycle that the byte that completes it is accepted.
// Throughput: one byte per cycle while in_ready is high; an item that yields two tokens pushes both at once.
// A four-entry token queue decouples the scanner from the output handshake.
// in_ready drops only while the queue has fewer than two free entries.
// Reset is asynchronous and active low; it empties the queue and returns the scanner to idle.
`timescale 1ns / 1ps

module byte_stream_lexer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] byte_in,
    input  logic       end_of_input,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] token_kind,
    output logic [6:0] token_length,
    output logic [7:0] first_char,
    output logic       last_of_run
);

    bsl_pkg::scan_out_t     scan_out;
    bsl_pkg::token_t        head_tok;
    bsl_pkg::queue_status_t status;
    logic                   fire;
    logic                   pop;

    assign in_ready     = status.room2;
    assign fire         = in_valid && in_ready;
    assign out_valid    = (status.level != '0);
    assign pop          = out_valid && out_ready;
    assign token_kind   = head_tok.kind;
    assign token_length = head_tok.length;
    assign first_char   = head_tok.first;
    assign last_of_run  = head_tok.last;

    bsl_scanner u_scanner (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .byte_in      (byte_in),
        .end_of_input (end_of_input),
        .scan_out     (scan_out)
    );

    bsl_out_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .scan_out (scan_out),
        .pop      (pop),
        .head_tok (head_tok),
        .status   (status)
    );

    // An end-of-input request always leaves a token waiting in the next cycle.
    a_eof_gives_token: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && end_of_input) |=> out_valid)
        else $error("end of input produced no token");

    // The queue never holds more entries than it has.
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.level <= bsl_pkg::CNT_W'(bsl_pkg::QUEUE_DEPTH))
        else $error("token queue overflow");

    // A second token in one cycle only follows a first one.
    a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
        scan_out.push1 |-> (scan_out.push0 && !scan_out.res0.last && scan_out.res1.last))
        else $error("token pair out of order");

    // The last token of an end-of-input request is the end token.
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && end_of_input && !scan_out.push1) |->
        (scan_out.res0.kind == bsl_pkg::KIND_END))
        else $error("end token missing");

endmodule

@@ hw/rtl/bsl_scanner.sv @@
`timescale 1ns / 1ps

module bsl_scanner (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          byte_in,
    input  logic                end_of_input,
    output bsl_pkg::scan_out_t  scan_out
);

    bsl_pkg::mode_t mode_reg, mode_next;
    logic [6:0]     len_reg, len_next;
    bsl_pkg::kw_t   kw_reg, kw_next_s;
    logic [7:0]     first_reg, first_next;

    bsl_pkg::token_t close_tok;
    bsl_pkg::token_t end_tok;
    bsl_pkg::token_t punct_tok;
    bsl_pkg::kind_t  close_kind;
    logic            is_l;
    logic            is_d;
    logic            is_s;
    logic            open_flag;

    always_comb
    begin
        is_l = bsl_pkg::is_letter(byte_in);
        is_d = bsl_pkg::is_digit(byte_in);
        is_s = bsl_pkg::is_space(byte_in);
        open_flag = (mode_reg != bsl_pkg::MODE_IDLE);

        if (mode_reg == bsl_pkg::MODE_IDENT)
        begin
            if (kw_reg == bsl_pkg::KW_INT)
            begin
                close_kind = bsl_pkg::KIND_INT;
            end
            else if (kw_reg == bsl_pkg::KW_IF)
            begin
                close_kind = bsl_pkg::KIND_IF;
            end
            else
            begin
                close_kind = bsl_pkg::KIND_IDENT;
            end
        end
        else
        begin
            close_kind = bsl_pkg::KIND_NUMBER;
        end

        close_tok = '{kind: close_kind, length: len_reg, first: first_reg, last: 1'b0};
        end_tok   = '{kind: bsl_pkg::KIND_END, length: 7'd3, first: 8'd0, last: 1'b1};
        punct_tok = '{kind: bsl_pkg::punct_kind(byte_in), length: 7'd1, first: byte_in,
                      last: 1'b1};

        mode_next  = mode_reg;
        len_next   = len_reg;
        kw_next_s  = kw_reg;
        first_next = first_reg;
        scan_out.push0 = 1'b0;
        scan_out.push1 = 1'b0;
        scan_out.res0  = close_tok;
        scan_out.res1  = end_tok;

        if (fire)
        begin
            if (end_of_input)
            begin
                mode_next  = bsl_pkg::MODE_IDLE;
                len_next   = 7'd0;
                kw_next_s  = bsl_pkg::KW_NONE;
                first_next = 8'd0;
                scan_out.push0 = 1'b1;
                if (open_flag)
                begin
                    scan_out.push1 = 1'b1;
                    scan_out.res1  = end_tok;
                end
                else
                begin
                    scan_out.res0 = end_tok;
                end
            end
            else if ((mode_reg == bsl_pkg::MODE_IDENT && (is_l || is_d)) ||
                     (mode_reg == bsl_pkg::MODE_NUMBER && is_d))
            begin
                if (len_reg < bsl_pkg::MAX_STORED)
                begin
                    len_next  = len_reg + 7'd1;
                    kw_next_s = bsl_pkg::kw_next(kw_reg, byte_in);
                end
            end
            else
            begin
                mode_next  = bsl_pkg::MODE_IDLE;
                len_next   = 7'd0;
                kw_next_s  = bsl_pkg::KW_NONE;
                first_next = 8'd0;
                if (is_l || is_d)
                begin
                    mode_next  = is_l ? bsl_pkg::MODE_IDENT : bsl_pkg::MODE_NUMBER;
                    len_next   = 7'd1;
                    first_next = byte_in;
                    kw_next_s  = is_l ? bsl_pkg::kw_next(bsl_pkg::KW_NONE, byte_in)
                                      : bsl_pkg::KW_DEAD;
                end
                if (open_flag)
                begin
                    scan_out.push0 = 1'b1;
                    if (!is_l && !is_d && !is_s)
                    begin
                        scan_out.push1 = 1'b1;
                        scan_out.res1  = punct_tok;
                    end
                    else
                    begin
                        scan_out.res0.last = 1'b1;
                    end
                end
                else if (!is_l && !is_d && !is_s)
                begin
                    scan_out.push0 = 1'b1;
                    scan_out.res0  = punct_tok;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= bsl_pkg::MODE_IDLE;
            len_reg   <= 7'd0;
            kw_reg    <= bsl_pkg::KW_NONE;
            first_reg <= 8'd0;
        end
        else
        begin
            mode_reg  <= mode_next;
            len_reg   <= len_next;
            kw_reg    <= kw_next_s;
            first_reg <= first_next;
        end
    end

endmodule

@@ hw/rtl/bsl_out_queue.sv @@
`timescale 1ns / 1ps

module bsl_out_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bsl_pkg::scan_out_t      scan_out,
    input  logic                    pop,
    output bsl_pkg::token_t         head_tok,
    output bsl_pkg::queue_status_t  status
);

    bsl_pkg::token_t mem_reg [bsl_pkg::QUEUE_DEPTH];

    logic [bsl_pkg::PTR_W-1:0] head_reg, head_next;
    logic [bsl_pkg::PTR_W-1:0] tail_reg, tail_next;
    logic [bsl_pkg::CNT_W-1:0] count_reg, count_next;
    logic [bsl_pkg::PTR_W-1:0] tail_plus1;

    always_comb
    begin
        tail_plus1 = tail_reg + bsl_pkg::PTR_W'(1);
        tail_next  = tail_reg + bsl_pkg::PTR_W'(scan_out.push0)
                              + bsl_pkg::PTR_W'(scan_out.push1);
        head_next  = head_reg + bsl_pkg::PTR_W'(pop);
        count_next = count_reg + bsl_pkg::CNT_W'(scan_out.push0)
                               + bsl_pkg::CNT_W'(scan_out.push1)
                               - bsl_pkg::CNT_W'(pop);
        head_tok     = mem_reg[head_reg];
        status.level = count_reg;
        status.room2 = (count_reg <= bsl_pkg::CNT_W'(bsl_pkg::QUEUE_DEPTH - 2));
    end

    always_ff @(posedge clk)
    begin
        if (scan_out.push0)
        begin
            mem_reg[tail_reg] <= scan_out.res0;
        end
        if (scan_out.push1)
        begin
            mem_reg[tail_plus1] <= scan_out.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule
